// ===== src/cpfd_pkg.sv =====
// Shared constants, types and helpers for the coherent PSK/FSK demodulator.
`timescale 1ns / 1ps

package cpfd_pkg;

    localparam int SINE_ADDR_BITS_DEF  = 10;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int MAX_PERIOD_BITS_DEF = 12;

    localparam int PHASE_BITS = 16;
    localparam int SINE_BITS  = 16;
    localparam int SUM_BITS   = 48;
    localparam int SPB_BITS   = 12;

    localparam logic [SPB_BITS-1:0] SPB_RESET = SPB_BITS'(100);

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPB    = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_A = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_B = CFG_INDEX_BITS'(3);

    localparam logic MODE_PSK = 1'b0;
    localparam logic MODE_FSK = 1'b1;

    // correlator result handed to the decision stage
    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum_a;
        logic signed [SUM_BITS-1:0] sum_b;
        logic                       last;
    } corr_t;

    // a period of zero behaves as one
    function automatic logic [SPB_BITS-1:0] eff_period(input logic [SPB_BITS-1:0] spb);
        return (spb == '0) ? SPB_BITS'(1) : spb;
    endfunction

endpackage

// ===== src/coherent_psk_fsk_demodulator_core.sv =====
// Top level of the coherent PSK/FSK correlation demodulator.
`timescale 1ns / 1ps

// Usage
//   s_valid/s_ready/s_sample: one received Q1.14 sample per transaction.
//   m_valid/m_ready/m_bit_value: one demodulated bit per transaction, at the
//   end of each bit period of samples_per_bit samples.
//   cfg_valid/cfg_ready/cfg_index/cfg_data: register writes (0 mode,
//   1 samples_per_bit, 2 carrier_step_a, 3 carrier_step_b); other indexes
//   are ignored. cfg_ready is always high. Write only with the pipeline empty.
// Timing
//   One sample per clock while no bit waits on m_ready (see Stall). A bit appears
//   on m_valid after the last sample of its period is accepted and passes the sine
//   ROM read, product register, sum register, then the decision register.
// Reset
//   aresetn clears the phase accumulators, sums, counters and all valid
//   flags, and loads register defaults (PSK, 100 samples per bit, steps 0).
// Stall
//   While a bit waits on m_ready, samples keep flowing until the next bit
//   end reaches the decision stage; then s_ready drops until the bit is taken.

module coherent_psk_fsk_demodulator_core
    import cpfd_pkg::*;
#(
    parameter int SINE_ADDR_BITS  = SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int MAX_PERIOD_BITS = MAX_PERIOD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_bit_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    localparam logic [SPB_BITS-1:0] SPB_MASK = (MAX_PERIOD_BITS >= SPB_BITS) ? '1 :
                                               SPB_BITS'((1 << MAX_PERIOD_BITS) - 1);

    logic                          mode_reg;
    logic [SPB_BITS-1:0]           spb_reg;
    logic [PHASE_BITS-1:0]         step_a_reg;
    logic [PHASE_BITS-1:0]         step_b_reg;
    logic                          cfg_wr;

    logic [PHASE_BITS-1:0]         phase_a_reg;
    logic [PHASE_BITS-1:0]         phase_b_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          v1_reg;
    logic                          v1_next;
    logic                          accept;
    logic                          move1;
    logic                          corr_ready;

    logic signed [SINE_BITS-1:0]   sine_a;
    logic signed [SINE_BITS-1:0]   sine_b;
    logic                          corr_valid;
    logic                          dec_ready;
    corr_t                         corr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_PSK;
            spb_reg    <= SPB_RESET;
            step_a_reg <= '0;
            step_b_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_SPB:    spb_reg    <= cfg_data[SPB_BITS-1:0] & SPB_MASK;
                CFG_STEP_A: step_a_reg <= cfg_data[PHASE_BITS-1:0];
                CFG_STEP_B: step_b_reg <= cfg_data[PHASE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign move1   = v1_reg && corr_ready;
    assign s_ready = !v1_reg || move1;
    assign accept  = s_valid && s_ready;
    assign v1_next = accept || (v1_reg && !move1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            phase_a_reg <= '0;
            phase_b_reg <= '0;
        end else begin
            v1_reg <= v1_next;
            if (accept) begin
                phase_a_reg <= phase_a_reg + step_a_reg;
                phase_b_reg <= phase_b_reg + step_b_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
        end
    end

    cpfd_sine_rom #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom (
        .aclk   (aclk),
        .rd_en  (accept),
        .addr_a (phase_a_reg[PHASE_BITS-1 -: SINE_ADDR_BITS]),
        .addr_b (phase_b_reg[PHASE_BITS-1 -: SINE_ADDR_BITS]),
        .sine_a (sine_a),
        .sine_b (sine_b)
    );

    cpfd_correlator #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .MAX_PERIOD_BITS (MAX_PERIOD_BITS)
    ) u_corr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .spb       (spb_reg),
        .in_valid  (v1_reg),
        .in_ready  (corr_ready),
        .sample    (sample_reg),
        .sine_a    (sine_a),
        .sine_b    (sine_b),
        .out_valid (corr_valid),
        .out_ready (dec_ready),
        .corr      (corr)
    );

    cpfd_decision #(
        .MAX_PERIOD_BITS (MAX_PERIOD_BITS)
    ) u_dec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .mode        (mode_reg),
        .spb         (spb_reg),
        .in_valid    (corr_valid),
        .in_ready    (dec_ready),
        .corr        (corr),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bit_value (m_bit_value)
    );

endmodule

// ===== src/cpfd_sine_rom.sv =====
// Dual-port quarter-wave sine ROM with registered read, Q1.14 output.
`timescale 1ns / 1ps

module cpfd_sine_rom
    import cpfd_pkg::*;
#(
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [SINE_ADDR_BITS-1:0]   addr_a,
    input  logic [SINE_ADDR_BITS-1:0]   addr_b,
    output logic signed [SINE_BITS-1:0] sine_a,
    output logic signed [SINE_BITS-1:0] sine_b
);

    localparam int QUARTER   = 1 << (SINE_ADDR_BITS - 2);
    localparam int QUARTER_SHIFT = SINE_ADDR_BITS - 2;
    localparam int IDX_BITS  = SINE_ADDR_BITS - 1;
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
    localparam logic [63:0] HPI_STEP    = HALF_PI_Q60 / QUARTER;
    localparam logic [63:0] HPI_REM     = HALF_PI_Q60 % QUARTER;
    localparam logic [IDX_BITS-1:0] QUARTER_IDX = IDX_BITS'(QUARTER);

    typedef logic signed [SINE_BITS-1:0] qtab_t [QUARTER+1];

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] bh;
        logic [63:0] bl;
        ah = a >> 32;
        al = a & 64'hFFFF_FFFF;
        bh = b >> 32;
        bl = b & 64'hFFFF_FFFF;
        return ((ah * bh) << 4) + ((ah * bl + al * bh) >> 28) + ((al * bl) >> 60);
    endfunction

    // odd powers of x over (2n)(2n+1), alternating sign
    function automatic logic signed [SINE_BITS-1:0] quarter_sine(input int j);
        logic [63:0] jj;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        jj   = 64'(j);
        x    = HPI_STEP * jj + ((HPI_REM * jj) >> QUARTER_SHIFT);
        x2   = mul_q60(x, x);
        term = x;
        acc  = x;
        term = mul_q60(term, x2) / 64'd6;
        acc  = acc - term;
        term = mul_q60(term, x2) / 64'd20;
        acc  = acc + term;
        term = mul_q60(term, x2) / 64'd42;
        acc  = acc - term;
        term = mul_q60(term, x2) / 64'd72;
        acc  = acc + term;
        term = mul_q60(term, x2) / 64'd110;
        acc  = acc - term;
        term = mul_q60(term, x2) / 64'd156;
        acc  = acc + term;
        term = mul_q60(term, x2) / 64'd210;
        acc  = acc - term;
        term = mul_q60(term, x2) / 64'd272;
        acc  = acc + term;
        term = mul_q60(term, x2) / 64'd342;
        acc  = acc - term;
        term = mul_q60(term, x2) / 64'd420;
        acc  = acc + term;
        term = mul_q60(term, x2) / 64'd506;
        acc  = acc - term;
        term = mul_q60(term, x2) / 64'd600;
        acc  = acc + term;
        acc = (acc + (64'd1 << 45)) >> 46;
        return SINE_BITS'(acc);
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int k = 0; k <= QUARTER; k++) begin
            t[k] = quarter_sine(k);
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    logic [IDX_BITS-1:0]        idx_a;
    logic [IDX_BITS-1:0]        idx_b;
    logic signed [SINE_BITS-1:0] q_a_reg;
    logic signed [SINE_BITS-1:0] q_b_reg;
    logic                        neg_a_reg;
    logic                        neg_b_reg;

    // odd quadrants read mirrored, second half-cycle negated
    assign idx_a = addr_a[SINE_ADDR_BITS-2] ?
                   (QUARTER_IDX - IDX_BITS'(addr_a[SINE_ADDR_BITS-3:0])) :
                   IDX_BITS'(addr_a[SINE_ADDR_BITS-3:0]);
    assign idx_b = addr_b[SINE_ADDR_BITS-2] ?
                   (QUARTER_IDX - IDX_BITS'(addr_b[SINE_ADDR_BITS-3:0])) :
                   IDX_BITS'(addr_b[SINE_ADDR_BITS-3:0]);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            q_a_reg   <= QTAB[idx_a];
            q_b_reg   <= QTAB[idx_b];
            neg_a_reg <= addr_a[SINE_ADDR_BITS-1];
            neg_b_reg <= addr_b[SINE_ADDR_BITS-1];
        end
    end

    assign sine_a = neg_a_reg ? -q_a_reg : q_a_reg;
    assign sine_b = neg_b_reg ? -q_b_reg : q_b_reg;

endmodule

// ===== src/cpfd_correlator.sv =====
// Carrier products, saturating correlation sums and bit-period counter.
`timescale 1ns / 1ps

module cpfd_correlator
    import cpfd_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int MAX_PERIOD_BITS = MAX_PERIOD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [SPB_BITS-1:0]           spb,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SINE_BITS-1:0]   sine_a,
    input  logic signed [SINE_BITS-1:0]   sine_b,
    output logic                          out_valid,
    input  logic                          out_ready,
    output corr_t                         corr
);

    localparam int PROD_BITS = SAMPLE_BITS + SINE_BITS;
    localparam int P         = MAX_PERIOD_BITS;
    localparam int CMP_BITS  = ((P > SPB_BITS) ? P : SPB_BITS) + 1;
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    logic                        v2_reg;
    logic                        v2_next;
    logic signed [PROD_BITS-1:0] prod_a_reg;
    logic signed [PROD_BITS-1:0] prod_b_reg;
    logic signed [PROD_BITS-1:0] prod_a_next;
    logic signed [PROD_BITS-1:0] prod_b_next;

    logic                        v3_reg;
    logic                        v3_next;
    logic signed [SUM_BITS-1:0]  sum_a_reg;
    logic signed [SUM_BITS-1:0]  sum_b_reg;
    logic signed [SUM_BITS-1:0]  sum_a_next;
    logic signed [SUM_BITS-1:0]  sum_b_next;
    logic                        last_reg;
    logic                        last_next;
    logic                        start_reg;
    logic                        start_next;
    logic [P-1:0]                cnt_reg;
    logic [P-1:0]                cnt_next;
    logic [P-1:0]                cnt_inc;

    logic                        load2;
    logic                        load3;
    logic                        ready3;

    function automatic logic signed [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0]  base,
        input logic signed [PROD_BITS-1:0] prod
    );
        logic signed [SUM_BITS:0] wide;
        wide = (SUM_BITS+1)'(base) + (SUM_BITS+1)'(prod);
        if (wide[SUM_BITS] != wide[SUM_BITS-1]) begin
            return wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end
        return wide[SUM_BITS-1:0];
    endfunction

    assign ready3   = !v3_reg || out_ready;
    assign load3    = v2_reg && ready3;
    assign in_ready = !v2_reg || load3;
    assign load2    = in_valid && in_ready;

    assign prod_a_next = PROD_BITS'(sample) * PROD_BITS'(sine_a);
    assign prod_b_next = PROD_BITS'(sample) * PROD_BITS'(sine_b);

    always_comb begin
        v2_next    = load2 || (v2_reg && !load3);
        v3_next    = load3 || (v3_reg && !out_ready);
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        last_next  = last_reg;
        start_next = start_reg;
        cnt_next   = cnt_reg;
        cnt_inc    = cnt_reg + P'(1);
        if (load3) begin
            sum_a_next = sat_add(start_reg ? '0 : sum_a_reg, prod_a_reg);
            sum_b_next = sat_add(start_reg ? '0 : sum_b_reg, prod_b_reg);
            last_next  = (CMP_BITS'(cnt_inc) >= CMP_BITS'(eff_period(spb))) ||
                         (cnt_inc == '0);
            start_next = last_next;
            cnt_next   = last_next ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            last_reg  <= 1'b0;
            start_reg <= 1'b1;
            cnt_reg   <= '0;
        end else begin
            v2_reg    <= v2_next;
            v3_reg    <= v3_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            last_reg  <= last_next;
            start_reg <= start_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load2) begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
    end

    assign out_valid  = v3_reg;
    assign corr.sum_a = sum_a_reg;
    assign corr.sum_b = sum_b_reg;
    assign corr.last  = last_reg;

endmodule

// ===== src/cpfd_decision.sv =====
// Per-sample vote, ones counter and majority decision with output register.
`timescale 1ns / 1ps

module cpfd_decision
    import cpfd_pkg::*;
#(
    parameter int MAX_PERIOD_BITS = MAX_PERIOD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                mode,
    input  logic [SPB_BITS-1:0] spb,
    input  logic                in_valid,
    output logic                in_ready,
    input  corr_t               corr,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_bit_value
);

    localparam int P        = MAX_PERIOD_BITS;
    localparam int CMP_BITS = ((P > SPB_BITS) ? P : SPB_BITS) + 1;

    logic                     out_free;
    logic                     take;
    logic                     vote;
    logic signed [SUM_BITS:0] diff;
    logic [P-1:0]             ones_reg;
    logic [P-1:0]             ones_next;
    logic [P-1:0]             ones_new;
    logic [CMP_BITS-1:0]      twice;
    logic [CMP_BITS-1:0]      period;
    logic                     bit_dec;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic                     m_bit_value_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign in_ready = !corr.last || out_free;
    assign take     = in_valid && in_ready;

    assign diff     = (SUM_BITS+1)'(corr.sum_a) - (SUM_BITS+1)'(corr.sum_b);
    assign vote     = (mode == MODE_FSK) ? (diff > 0) : corr.sum_a[SUM_BITS-1];
    assign ones_new = ones_reg + P'(vote);
    assign twice    = CMP_BITS'({ones_new, 1'b0});
    assign period   = CMP_BITS'(eff_period(spb));
    assign bit_dec  = (mode == MODE_FSK) ? (twice < period) : (twice > period);

    always_comb begin
        ones_next    = ones_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (take) begin
            ones_next = corr.last ? '0 : ones_new;
            if (corr.last) begin
                m_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ones_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ones_reg    <= ones_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && corr.last) begin
            m_bit_value_reg <= bit_dec;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bit_value = m_bit_value_reg;

    a_last_restarts_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && corr.last) |=> (m_valid_reg && ones_reg == '0))
        else $error("count not restarted after a bit decision");

    a_last_waits_for_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && corr.last && m_valid_reg && !m_ready) |-> !in_ready)
        else $error("bit end taken while a result is still pending");

    a_count_holds_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid |=> $stable(ones_reg))
        else $error("ones count changed without a transaction");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the coherent PSK/FSK correlation demodulator core.
`timescale 1ns / 1ps

module testbench;
    import cpfd_pkg::*;

    localparam int     LUT_SIZE     = 1 << SINE_ADDR_BITS_DEF;
    localparam int     LUT_SHIFT    = PHASE_BITS - SINE_ADDR_BITS_DEF;
    localparam int     DRAIN_CYCLES = 10;
    localparam int     RANDOM_ITEMS = 1900;
    localparam longint SUM_HI       = (longint'(1) << (SUM_BITS - 1)) - 1;
    localparam longint SUM_LO       = -SUM_HI - 1;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_valid   = 1'b0;
    logic                              s_ready;
    logic signed [SAMPLE_BITS_DEF-1:0] s_sample  = '0;
    logic                              m_valid;
    logic                              m_ready   = 1'b0;
    logic                              m_bit_value;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [CFG_INDEX_BITS-1:0]         cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]          cfg_data  = '0;

    coherent_psk_fsk_demodulator_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bit_value (m_bit_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 aclk = ~aclk;

    int sine_lut[LUT_SIZE];

    // register shadow and demodulator state
    logic                  cur_mode;
    logic [SPB_BITS-1:0]   cur_spb;
    logic [PHASE_BITS-1:0] cur_step_a, cur_step_b;
    logic [PHASE_BITS-1:0] nco_a, nco_b;
    longint                corr_a, corr_b;
    logic [SPB_BITS-1:0]   pos_in_bit, votes;

    logic signed [SAMPLE_BITS_DEF-1:0] sample_q[$];
    bit                                bits_due[$];

    // test signal generator
    logic                  gen_mode;
    logic [PHASE_BITS-1:0] gen_ph_a, gen_ph_b, gen_step_a, gen_step_b;

    bit calm = 1'b0;
    int n_err = 0;
    int n_bits = 0;
    int n_samples = 0;
    int n_settings = 0;

    function automatic void queue_sample(input logic signed [SAMPLE_BITS_DEF-1:0] v);
        sample_q.insert(sample_q.size(), v);
    endfunction

    function automatic longint unsigned mul_q60(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned ah = a >> 32;
        longint unsigned al = a & 64'hFFFF_FFFF;
        longint unsigned bh = b >> 32;
        longint unsigned bl = b & 64'hFFFF_FFFF;
        return ((ah * bh) << 4) + ((ah * bl + al * bh) >> 28) + ((al * bl) >> 60);
    endfunction

    // Taylor series in Q60 on the first quadrant, rounded to Q1.14
    function automatic int quarter_sine(input int j);
        longint unsigned qtr = LUT_SIZE / 4;
        longint unsigned hpi = 64'h1921_FB54_442D_1846;
        longint unsigned jj  = j;
        longint unsigned x, x2, term, acc;
        x    = (hpi / qtr) * jj + ((hpi % qtr) * jj) / qtr;
        x2   = mul_q60(x, x);
        term = x;
        acc  = x;
        for (int n = 1; n <= 12; n++) begin
            term = mul_q60(term, x2) / 64'(4 * n * n + 2 * n);
            if (n % 2) begin
                acc -= term;
            end else begin
                acc += term;
            end
        end
        return int'((acc + (64'd1 << 45)) >> 46);
    endfunction

    function automatic longint clamp_sum(input longint v);
        if (v > SUM_HI) return SUM_HI;
        if (v < SUM_LO) return SUM_LO;
        return v;
    endfunction

    function automatic void demod_sample(input logic signed [SAMPLE_BITS_DEF-1:0] smp);
        logic [SPB_BITS-1:0] period;
        bit                  vote;
        int unsigned         twice;
        corr_a = clamp_sum(corr_a + longint'(smp) * longint'(sine_lut[nco_a >> LUT_SHIFT]));
        corr_b = clamp_sum(corr_b + longint'(smp) * longint'(sine_lut[nco_b >> LUT_SHIFT]));
        nco_a  = nco_a + cur_step_a;
        nco_b  = nco_b + cur_step_b;
        vote   = (cur_mode == MODE_FSK) ? (corr_a - corr_b > 0) : (corr_a < 0);
        votes      = votes + vote;
        pos_in_bit = pos_in_bit + 1'b1;
        period = (cur_spb == '0) ? SPB_BITS'(1) : cur_spb;
        // also closes a bit early when the period was cut below the count
        if (pos_in_bit >= period || pos_in_bit == '0) begin
            twice = 2 * votes;
            bits_due.insert(bits_due.size(),
                            (cur_mode == MODE_FSK) ? (twice < period) : (twice > period));
            corr_a     = 0;
            corr_b     = 0;
            pos_in_bit = '0;
            votes      = '0;
        end
    endfunction

    function automatic logic [PHASE_BITS-1:0] pick_step();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return 16'h8000;
            5: return 16'($urandom);
            default: return 16'($urandom_range(200, 6000));
        endcase
    endfunction

    // one sample of a clean modulated tone plus noise
    function automatic logic signed [15:0] tone_sample(input bit one, input int amp,
                                                       input int noise);
        int c, v;
        if (gen_mode == MODE_FSK) begin
            c = one ? sine_lut[gen_ph_b >> LUT_SHIFT] : sine_lut[gen_ph_a >> LUT_SHIFT];
        end else begin
            c = one ? -sine_lut[gen_ph_a >> LUT_SHIFT] : sine_lut[gen_ph_a >> LUT_SHIFT];
        end
        gen_ph_a += gen_step_a;
        gen_ph_b += gen_step_b;
        v = amp * c / 16384 + int'($urandom_range(2 * noise)) - noise;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input logic m, input logic [SPB_BITS-1:0] spb,
                                 input logic [PHASE_BITS-1:0] sa,
                                 input logic [PHASE_BITS-1:0] sb);
        write_reg(CFG_MODE, {15'($urandom), m});
        write_reg(CFG_SPB, {4'($urandom), spb});
        write_reg(CFG_STEP_A, sa);
        write_reg(CFG_STEP_B, sb);
        cfg_valid  <= 1'b0;
        gen_mode   = m;
        gen_step_a = sa;
        gen_step_b = sb;
        gen_ph_a   = nco_a;
        gen_ph_b   = nco_b;
        n_settings++;
    endtask

    // sender holds off until every bit is out and the pipeline has emptied
    task automatic wait_quiet();
        do begin
            @(posedge aclk);
            #1;
        end while (sample_q.size() != 0 || s_valid || bits_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_mode   = MODE_PSK;
            cur_spb    = SPB_RESET;
            cur_step_a = '0;
            cur_step_b = '0;
            nco_a      = '0;
            nco_b      = '0;
            corr_a     = 0;
            corr_b     = 0;
            pos_in_bit = '0;
            votes      = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MODE:   cur_mode   = cfg_data[0];
                    CFG_SPB:    cur_spb    = cfg_data[SPB_BITS-1:0];
                    CFG_STEP_A: cur_step_a = cfg_data;
                    CFG_STEP_B: cur_step_b = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                demod_sample(s_sample);
                n_samples++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (sample_q.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
                s_valid  <= 1'b1;
                s_sample <= sample_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 9);
    end

    always @(posedge aclk) begin
        bit want;
        if (aresetn && m_valid && m_ready) begin
            if (bits_due.size() == 0) begin
                $error("bit_value: no bit expected, got %0b", m_bit_value);
                n_err++;
            end else begin
                want = bits_due.pop_front();
                if (m_bit_value !== want) begin
                    $error("bit_value: expected %0b, got %0b", want, m_bit_value);
                    n_err++;
                end
                n_bits++;
            end
        end
    end

    initial begin
        int unsigned         rand_items;
        logic [SPB_BITS-1:0] spb, spb_eff;
        int                  amp, noise, nsamp;
        bit                  m, one, noisy;

        for (int k = 0; k < LUT_SIZE; k++) begin
            int quad, j, v;
            quad = k / (LUT_SIZE / 4);
            j    = k % (LUT_SIZE / 4);
            v    = (quad % 2) ? quarter_sine(LUT_SIZE / 4 - j) : quarter_sine(j);
            sine_lut[k] = (quad >= 2) ? -v : v;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero period: every sample closes a bit; full-scale, zero and small samples
        apply_setting(MODE_PSK, '0, 16'h4000, 16'hFFFF);
        queue_sample(16'sh7FFF);
        queue_sample(16'sh8000);
        queue_sample(16'sh0000);
        queue_sample(16'shFFFF);
        queue_sample(16'sh0001);
        queue_sample(16'sh4000);
        wait_quiet();

        apply_setting(MODE_FSK, 12'd2, 16'h0000, 16'h4000);
        queue_sample(16'sh7FFF);
        queue_sample(16'sh8000);
        queue_sample(16'sh8000);
        queue_sample(16'sh7FFF);
        wait_quiet();

        // unused register indexes are ignored; longest period, then cut short mid-bit
        write_reg(CFG_STEP_B + 1'b1, 16'hFFFF);
        write_reg('1, 16'h0000);
        apply_setting(MODE_PSK, 12'hFFF, 16'h2000, 16'h0000);
        repeat (6) queue_sample(-16'sd20000);
        wait_quiet();
        write_reg(CFG_SPB, 16'h0004);
        cfg_valid <= 1'b0;
        queue_sample(16'sh1234);
        wait_quiet();

        // mode switched half way through a bit
        apply_setting(MODE_PSK, 12'd6, 16'h0800, 16'h1000);
        repeat (3) queue_sample(16'($urandom));
        wait_quiet();
        write_reg(CFG_MODE, {15'h7FFF, MODE_FSK});
        cfg_valid <= 1'b0;
        repeat (3) queue_sample(16'($urandom));

        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            wait_quiet();
            calm = (rand_items >= 600 && rand_items < 1000);
            if ($urandom_range(9) == 0) begin
                write_reg(CFG_INDEX_BITS'($urandom_range(int'(CFG_STEP_B) + 1,
                                                         (1 << CFG_INDEX_BITS) - 1)),
                          16'($urandom));
            end
            m = $urandom_range(1);
            case ($urandom_range(19))
                0: spb = '0;
                1: spb = $urandom_range(1000, 4095);
                2, 3: spb = $urandom_range(25, 200);
                default: spb = $urandom_range(1, 24);
            endcase
            apply_setting(m, spb, pick_step(), pick_step());
            spb_eff = (spb == '0) ? SPB_BITS'(1) : spb;
            if (spb > 999) begin
                nsamp = $urandom_range(10, 60);
            end else begin
                nsamp = spb_eff * ((spb_eff > 24) ? $urandom_range(1, 2) : $urandom_range(1, 6));
                // leave a part-filled bit for the next setting
                if ($urandom_range(2) == 0) nsamp += $urandom_range(spb_eff - 1);
            end
            noisy = ($urandom_range(4) == 0);
            case ($urandom_range(2))
                0: noise = 0;
                1: noise = 2000;
                default: noise = 12000;
            endcase
            for (int i = 0; i < nsamp; i++) begin
                if (i % spb_eff == 0) begin
                    one = $urandom_range(1);
                    amp = $urandom_range(16383);
                end
                queue_sample(noisy ? 16'($urandom) : tone_sample(one, amp, noise));
            end
            rand_items += nsamp;
        end
        calm = 1'b0;

        wait_quiet();
        $display("Checked %0d bits from %0d samples over %0d register settings,",
                 n_bits, n_samples, n_settings);
        $display("PSK and FSK, periods zero to 4095, mid-bit changes, noisy and clean tones.");
        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== coherent_psk_fsk_demodulator_core.f =====
src/cpfd_pkg.sv
src/cpfd_sine_rom.sv
src/cpfd_correlator.sv
src/cpfd_decision.sv
src/coherent_psk_fsk_demodulator_core.sv
tb/testbench.sv
